>>> src/sboa_pkg.sv
// ----------------------------------------------------------------------------
// sboa_pkg
// Shared sizes, codes and types for the split-only buddy allocator.
// ----------------------------------------------------------------------------
package sboa_pkg;

	localparam int NUM_SB     = 8;
	localparam int MINBLK     = 1024;
	localparam int MIN_BYTES  = 64;

	localparam int SB_W       = $clog2(NUM_SB);
	localparam int IDX_W      = $clog2(MINBLK);
	localparam int ADDR_W     = SB_W + IDX_W;
	localparam int TOTAL      = NUM_SB * MINBLK;
	localparam int CMIN       = $clog2(MIN_BYTES);
	localparam int NCLS       = IDX_W + 1;
	localparam int K_W        = $clog2(NCLS + 1);
	localparam int CLS_W      = 5;
	localparam int BYTES_W    = 17;
	localparam int CNT_W      = $clog2(NUM_SB + 1);
	localparam int SB_BYTES   = MIN_BYTES * MINBLK;

	localparam logic [K_W-1:0] REC_NONE = '1;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OOM       = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
	} link_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_POP_W,
		S_NEW,
		S_SPLIT,
		S_ALLOC_END,
		S_FREE_CHK,
		S_PURGE_HEAD,
		S_PURGE_HEAD_W,
		S_PURGE_CUR_W,
		S_PURGE_WALK,
		S_PURGE_SKIP_W,
		S_RETURN,
		S_DONE
	} state_t;

endpackage

>>> src/split_only_buddy_allocator.sv
// ----------------------------------------------------------------------------
// split_only_buddy_allocator
// Power-of-two block allocator with per-class free stacks, no merging.
// ----------------------------------------------------------------------------
// channel  dir  handshake           beat payload
// in       in   in_valid/in_stall   mode, request_bytes, free_address
// out      out  out_valid/out_stall status, block_address, size_class
//
// one beat at a time under a sequencer sharing one shift/compare unit and one
// port pair on the link memory. allocate: accept, a scan of the classes upward,
// a pop or the claim of a superblock, halvings down to the fitting class, an end
// step and the load. free: accept, a record check and the load, plus on an
// emptied superblock a purge of its entries from every class stack and its
// return to the pool. after reset a clearing pass over all 8192 class records
// runs with in_stall high. a finished result waits in the output register; a new
// beat is taken meanwhile and its result waits until the old one is taken.
module split_only_buddy_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [16:0]                  request_bytes,
	input  logic [12:0]                  free_address,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [12:0]                  block_address,
	output logic [4:0]                   size_class
);

	localparam int AW = sboa_pkg::ADDR_W;
	localparam int KW = sboa_pkg::K_W;
	localparam int BW = sboa_pkg::BYTES_W;
	localparam int SW = sboa_pkg::SB_W;
	localparam int CW = sboa_pkg::CNT_W;
	localparam logic [KW-1:0] K_LAST = KW'(sboa_pkg::NCLS - 1);

	sboa_pkg::state_t state_q, state_d;

	sboa_pkg::link_t   head_q [sboa_pkg::NCLS];
	logic [BW-1:0]     used_q [sboa_pkg::NUM_SB];
	logic [SW-1:0]     ret_stack_q [sboa_pkg::NUM_SB];
	logic [CW-1:0]     ret_count_q, never_q;
	logic [AW-1:0]     clr_q;

	logic [BW-1:0]     size_q;
	logic [AW-1:0]     a_q, cur_q;
	logic [KW-1:0]     k_q, pk_q;
	logic [SW-1:0]     sb_q;
	sboa_pkg::link_t   cur_link_q;

	logic [1:0]        res_status_q;
	logic [AW-1:0]     res_addr_q;
	logic [4:0]        res_cls_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [AW-1:0]     block_address_q;
	logic [4:0]        size_class_q;

	// memories
	sboa_pkg::link_t   link_mem [sboa_pkg::TOTAL];
	logic [KW-1:0]     rec_mem  [sboa_pkg::TOTAL];
	sboa_pkg::link_t   link_rdata;
	logic [KW-1:0]     rec_rdata;

	logic              link_ren, link_wen, rec_ren, rec_wen;
	logic [AW-1:0]     link_raddr, link_waddr, rec_raddr, rec_waddr;
	sboa_pkg::link_t   link_wdata;
	logic [KW-1:0]     rec_wdata;

	// shared shift/compare unit
	logic [BW-1:0]     blk_bytes, half_bytes;
	logic              fits, fits_half;
	logic [KW-1:0]     k_dn;
	logic [AW-1:0]     upper_addr;
	sboa_pkg::link_t   head_k, head_pk;
	logic [BW-1:0]     fr_bytes, used_fr, used_fr_new;
	logic [SW-1:0]     fr_sb;
	logic              accept, out_load, rec_ok;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != sboa_pkg::S_IDLE);
	assign out_load   = (state_q == sboa_pkg::S_DONE) && (!out_valid_q || !out_stall);

	assign blk_bytes  = BW'(sboa_pkg::MIN_BYTES) << k_q;
	assign half_bytes = blk_bytes >> 1;
	assign fits       = (size_q <= blk_bytes);
	assign fits_half  = (k_q != '0) && (size_q <= half_bytes);
	assign k_dn       = k_q - KW'(1);
	assign upper_addr = a_q + (AW'(1) << k_dn);
	assign head_k     = head_q[k_q];
	assign head_pk    = head_q[pk_q];

	assign rec_ok     = (rec_rdata < KW'(sboa_pkg::NCLS));
	assign fr_bytes   = BW'(sboa_pkg::MIN_BYTES) << rec_rdata;
	assign fr_sb      = a_q[AW-1 -: SW];
	assign used_fr    = used_q[fr_sb];
	assign used_fr_new = (used_fr >= fr_bytes) ? used_fr - fr_bytes : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sboa_pkg::S_CLEAR: begin
				if (clr_q == AW'(sboa_pkg::TOTAL - 1)) state_d = sboa_pkg::S_IDLE;
			end
			sboa_pkg::S_IDLE: begin
				if (accept) begin
					if (mode == sboa_pkg::MODE_FREE) state_d = sboa_pkg::S_FREE_CHK;
					else if (request_bytes > BW'(sboa_pkg::SB_BYTES)) state_d = sboa_pkg::S_DONE;
					else state_d = sboa_pkg::S_SCAN;
				end
			end
			sboa_pkg::S_SCAN: begin
				if (fits && head_k.valid) state_d = sboa_pkg::S_POP_W;
				else if (k_q == K_LAST) state_d = sboa_pkg::S_NEW;
			end
			sboa_pkg::S_POP_W: state_d = sboa_pkg::S_SPLIT;
			sboa_pkg::S_NEW: begin
				if (ret_count_q != '0 || never_q < CW'(sboa_pkg::NUM_SB))
					state_d = sboa_pkg::S_SPLIT;
				else
					state_d = sboa_pkg::S_DONE;
			end
			sboa_pkg::S_SPLIT: begin
				if (!fits_half) state_d = sboa_pkg::S_ALLOC_END;
			end
			sboa_pkg::S_ALLOC_END: state_d = sboa_pkg::S_DONE;
			sboa_pkg::S_FREE_CHK: begin
				if (rec_ok && used_fr_new == '0) state_d = sboa_pkg::S_PURGE_HEAD;
				else state_d = sboa_pkg::S_DONE;
			end
			sboa_pkg::S_PURGE_HEAD: begin
				if (head_pk.valid && head_pk.addr[AW-1 -: SW] == sb_q)
					state_d = sboa_pkg::S_PURGE_HEAD_W;
				else if (head_pk.valid)
					state_d = sboa_pkg::S_PURGE_CUR_W;
				else if (pk_q == K_LAST)
					state_d = sboa_pkg::S_RETURN;
			end
			sboa_pkg::S_PURGE_HEAD_W: state_d = sboa_pkg::S_PURGE_HEAD;
			sboa_pkg::S_PURGE_CUR_W:  state_d = sboa_pkg::S_PURGE_WALK;
			sboa_pkg::S_PURGE_WALK: begin
				if (cur_link_q.valid && cur_link_q.addr[AW-1 -: SW] == sb_q)
					state_d = sboa_pkg::S_PURGE_SKIP_W;
				else if (cur_link_q.valid)
					state_d = sboa_pkg::S_PURGE_CUR_W;
				else if (pk_q == K_LAST)
					state_d = sboa_pkg::S_RETURN;
				else
					state_d = sboa_pkg::S_PURGE_HEAD;
			end
			sboa_pkg::S_PURGE_SKIP_W: state_d = sboa_pkg::S_PURGE_WALK;
			sboa_pkg::S_RETURN: state_d = sboa_pkg::S_DONE;
			sboa_pkg::S_DONE: begin
				if (out_load) state_d = sboa_pkg::S_IDLE;
			end
			default: state_d = sboa_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		link_ren   = 1'b0;
		link_raddr = '0;
		link_wen   = 1'b0;
		link_waddr = '0;
		link_wdata = '0;
		rec_ren    = 1'b0;
		rec_raddr  = free_address;
		rec_wen    = 1'b0;
		rec_waddr  = '0;
		rec_wdata  = sboa_pkg::REC_NONE;
		case (state_q)
			sboa_pkg::S_CLEAR: begin
				rec_wen   = 1'b1;
				rec_waddr = clr_q;
			end
			sboa_pkg::S_IDLE: begin
				rec_ren = accept && (mode == sboa_pkg::MODE_FREE);
			end
			sboa_pkg::S_SCAN: begin
				link_ren   = fits && head_k.valid;
				link_raddr = head_k.addr;
			end
			sboa_pkg::S_SPLIT: begin
				link_wen   = fits_half;
				link_waddr = upper_addr;
				link_wdata = head_q[k_dn];
			end
			sboa_pkg::S_ALLOC_END: begin
				rec_wen   = 1'b1;
				rec_waddr = a_q;
				rec_wdata = k_q;
			end
			sboa_pkg::S_FREE_CHK: begin
				rec_wen    = rec_ok;
				rec_waddr  = a_q;
				link_wen   = rec_ok;
				link_waddr = a_q;
				link_wdata = head_q[rec_rdata];
			end
			sboa_pkg::S_PURGE_HEAD: begin
				link_ren   = head_pk.valid;
				link_raddr = head_pk.addr;
			end
			sboa_pkg::S_PURGE_WALK: begin
				link_ren   = cur_link_q.valid;
				link_raddr = cur_link_q.addr;
			end
			sboa_pkg::S_PURGE_SKIP_W: begin
				link_wen   = 1'b1;
				link_waddr = cur_q;
				link_wdata = link_rdata;
			end
			default: begin
				link_ren = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_wen) link_mem[link_waddr] <= link_wdata;
		if (link_ren) link_rdata <= link_mem[link_raddr];
		if (rec_wen) rec_mem[rec_waddr] <= rec_wdata;
		if (rec_ren) rec_rdata <= rec_mem[rec_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sboa_pkg::S_CLEAR;
			clr_q       <= '0;
			ret_count_q <= '0;
			never_q     <= '0;
			out_valid_q <= 1'b0;
			a_q         <= '0;
			k_q         <= '0;
			pk_q        <= '0;
			cur_q       <= '0;
			cur_link_q  <= '0;
			for (int i = 0; i < sboa_pkg::NCLS; i++) head_q[i] <= '0;
			for (int i = 0; i < sboa_pkg::NUM_SB; i++) used_q[i] <= '0;
			for (int i = 0; i < sboa_pkg::NUM_SB; i++) ret_stack_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				sboa_pkg::S_CLEAR: clr_q <= clr_q + AW'(1);
				sboa_pkg::S_IDLE: begin
					a_q  <= free_address;
					k_q  <= '0;
					pk_q <= '0;
				end
				sboa_pkg::S_SCAN: begin
					if (fits && head_k.valid) a_q <= head_k.addr;
					else k_q <= k_q + KW'(1);
				end
				sboa_pkg::S_POP_W: head_q[k_q] <= link_rdata;
				sboa_pkg::S_NEW: begin
					k_q <= K_LAST;
					if (ret_count_q != '0) begin
						ret_count_q <= ret_count_q - CW'(1);
						a_q <= {ret_stack_q[SW'(ret_count_q - CW'(1))], {sboa_pkg::IDX_W{1'b0}}};
					end else if (never_q < CW'(sboa_pkg::NUM_SB)) begin
						never_q <= never_q + CW'(1);
						a_q <= {never_q[SW-1:0], {sboa_pkg::IDX_W{1'b0}}};
					end
				end
				sboa_pkg::S_SPLIT: begin
					if (fits_half) begin
						k_q <= k_dn;
						head_q[k_dn] <= '{valid: 1'b1, addr: upper_addr};
					end
				end
				sboa_pkg::S_ALLOC_END: begin
					used_q[a_q[AW-1 -: SW]] <= used_q[a_q[AW-1 -: SW]] + blk_bytes;
				end
				sboa_pkg::S_FREE_CHK: begin
					if (rec_ok) begin
						head_q[rec_rdata] <= '{valid: 1'b1, addr: a_q};
						used_q[fr_sb] <= used_fr_new;
					end
				end
				sboa_pkg::S_PURGE_HEAD: begin
					if (head_pk.valid && head_pk.addr[AW-1 -: SW] != sb_q)
						cur_q <= head_pk.addr;
					else if (!head_pk.valid && pk_q != K_LAST)
						pk_q <= pk_q + KW'(1);
				end
				sboa_pkg::S_PURGE_HEAD_W: head_q[pk_q] <= link_rdata;
				sboa_pkg::S_PURGE_CUR_W:  cur_link_q <= link_rdata;
				sboa_pkg::S_PURGE_WALK: begin
					if (cur_link_q.valid && cur_link_q.addr[AW-1 -: SW] != sb_q)
						cur_q <= cur_link_q.addr;
					else if (!cur_link_q.valid && pk_q != K_LAST)
						pk_q <= pk_q + KW'(1);
				end
				sboa_pkg::S_PURGE_SKIP_W: cur_link_q <= link_rdata;
				sboa_pkg::S_RETURN: begin
					if (ret_count_q < CW'(sboa_pkg::NUM_SB)) begin
						ret_stack_q[SW'(ret_count_q)] <= sb_q;
						ret_count_q <= ret_count_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			sboa_pkg::S_IDLE: begin
				size_q       <= request_bytes;
				res_addr_q   <= (mode == sboa_pkg::MODE_FREE) ? free_address : '0;
				res_cls_q    <= '0;
				res_status_q <= (mode == sboa_pkg::MODE_FREE) ? sboa_pkg::ST_OK
				                                               : sboa_pkg::ST_TOO_LARGE;
			end
			sboa_pkg::S_NEW: begin
				if (ret_count_q == '0 && never_q >= CW'(sboa_pkg::NUM_SB))
					res_status_q <= sboa_pkg::ST_OOM;
			end
			sboa_pkg::S_ALLOC_END: begin
				res_status_q <= sboa_pkg::ST_OK;
				res_addr_q   <= a_q;
				res_cls_q    <= 5'(sboa_pkg::CMIN) + 5'(k_q);
			end
			sboa_pkg::S_FREE_CHK: begin
				sb_q <= fr_sb;
				if (rec_ok) res_cls_q <= 5'(sboa_pkg::CMIN) + 5'(rec_rdata);
				else res_status_q <= sboa_pkg::ST_BAD_FREE;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			status_q        <= res_status_q;
			block_address_q <= res_addr_q;
			size_class_q    <= res_cls_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign block_address = block_address_q;
	assign size_class    = size_class_q;

	// a returned superblock was handed out before
	a_ret_le_never: assert property (@(posedge clk) disable iff (!arst_n)
		ret_count_q <= never_q)
		else $error("returned pool count exceeds superblocks handed out");

	a_never_bound: assert property (@(posedge clk) disable iff (!arst_n)
		never_q <= CW'(sboa_pkg::NUM_SB))
		else $error("never-used count beyond pool");

	// a good result carries a legal class
	a_ok_class: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == sboa_pkg::ST_OK) |->
		(size_class >= 5'(sboa_pkg::CMIN) &&
		 size_class <= 5'(sboa_pkg::CMIN + sboa_pkg::NCLS - 1)))
		else $error("ok result with class out of range");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q == sboa_pkg::S_IDLE && out_valid))
		else $error("result load did not return to idle");

endmodule
